@@ rtl/csc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants of the stereo compressor
// Sizes, register indexes, fixed-point constants and the structs that
// travel between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package csc_pkg;

  // block sizes
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // datapath widths
  localparam int STATE_W = 48;   // per-channel levels, Q.32 magnitudes
  localparam int GAIN_W  = 31;   // stage gains, Q1.30, at most 2^30
  localparam int KQ_W    = 33;   // compression factor, Q.32
  localparam int MUL_W   = 64;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIV_W   = 64;
  localparam int GA_W    = 17;

  // configuration register widths and indexes
  localparam int LVL_W     = 16;
  localparam int WET_W     = 17;
  localparam int REL_W     = 37;
  localparam int CFG_W     = 37;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 2'd3;

  localparam logic [LVL_W-1:0] COMPRESS_RST = 16'd0;
  localparam logic [LVL_W-1:0] OUTPUT_RST   = 16'd32768;
  localparam logic [WET_W-1:0] WET_RST      = 17'd65536;
  localparam logic [REL_W-1:0] RELEASE_RST  = 37'd6442451;
  localparam logic [WET_W-1:0] WET_UNITY    = 17'd65536;

  // fixed-point constants
  localparam logic [63:0] ONE_Q32   = 64'd1 << 32;
  localparam logic [63:0] Q62       = 64'd1 << 62;
  localparam logic [GAIN_W-1:0] UNITY_Q30 = 31'd1 << 30;
  localparam logic [63:0] K_SCALE   = 64'd458752;  // 1.4 * 2^32 / 2^16 * 5
  localparam logic [63:0] SMOOTH_M  = 64'd999;

  // reciprocals for the constant divisions, exact below 2^38 and 2^50
  localparam logic [63:0] K_RECIP   = 64'd54975581389;       // ceil(2^38 / 5)
  localparam logic [63:0] SMOOTH_R  = 64'd288230376151712;   // ceil(2^58 / 1000)

  // shift amounts
  localparam int X1_SH   = SAMPLE_BITS - 1;
  localparam int DRY_SH  = 33 - SAMPLE_BITS;
  localparam int RES_SH  = 49 - SAMPLE_BITS;
  localparam int CTRL_SH = 32;
  localparam int REL_SH  = 48;
  localparam int G_SH    = 30;
  localparam int OUT_SH  = 15;
  localparam int GA_SH   = 44;
  localparam int K_SH    = 38;
  localparam int SMOOTH_SH = 58;

  localparam logic [63:0] SAT_MAG = 64'd1 << (SAMPLE_BITS - 1);

  // classified input item, front end to back end
  typedef struct packed {
    logic                   chbit;
    logic [CH_W-1:0]        ch;
    logic                   neg;
    logic                   pos;
    logic [SAMPLE_BITS-1:0] mag;
  } csc_item_t;

  // configuration registers
  typedef struct packed {
    logic [LVL_W-1:0] compress;
    logic [LVL_W-1:0] out_lvl;
    logic [WET_W-1:0] wet;
    logic [REL_W-1:0] rel_coeff;
  } csc_cfg_t;

  // one result item
  typedef struct packed {
    logic                          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [GA_W-1:0]               gain_applied;
  } csc_result_t;

endpackage

@@ rtl/csc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_if: stream interfaces of the stereo compressor
// Input sample channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface csc_in_if;
  import csc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, channel, sample_in, input ready);
  modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface csc_out_if;
  import csc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [GA_W-1:0]               gain_applied;

  modport source (output valid, channel_out, sample_out, gain_applied, input ready);
  modport sink   (input valid, channel_out, sample_out, gain_applied, output ready);
endinterface

@@ rtl/csc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_front: input classification and item queue
// Splits each sample into sign and magnitude, picks the channel index and
// holds up to two classified items for the back end.
// ----------------------------------------------------------------------------
module csc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_channel,
  input  logic [csc_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                         q_valid,
  input  logic                         q_ready,
  output csc_pkg::csc_item_t           q_item
);
  import csc_pkg::*;

  localparam int QDEPTH = 2;

  csc_item_t   item_c;
  csc_item_t   q_mem_r [QDEPTH];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  // sign and magnitude; a zero sample counts as not positive
  always_comb begin
    item_c.chbit = in_channel;
    item_c.ch    = (CHANNELS == 1) ? '0 : CH_W'(in_channel);
    item_c.neg   = in_sample[SAMPLE_BITS-1];
    item_c.mag   = item_c.neg ? (~in_sample + 1'b1) : in_sample;
    item_c.pos   = !item_c.neg && (in_sample != '0);
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_c;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/csc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_mul: multi-cycle 64 x 64 multiplier
// Forms the full product from four registered 32 x 32 partial products,
// accumulated one per cycle; done pulses when the product is ready.
// ----------------------------------------------------------------------------
module csc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [csc_pkg::MUL_W-1:0]   a,
  input  logic [csc_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [csc_pkg::PROD_W-1:0]  prod
);
  import csc_pkg::*;

  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  b_r;
  logic [MUL_W-1:0]  pp_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] pp_sh;
  logic [2:0]        step_r;
  logic [1:0]        pstep_r;
  logic              pp_vld_r;
  logic              busy_r;
  logic              done_r;
  logic [HALF-1:0]   a_half;
  logic [HALF-1:0]   b_half;

  // operand halves for this step: a0b0, a0b1, a1b0, a1b1
  assign a_half = step_r[1] ? a_r[MUL_W-1:HALF] : a_r[HALF-1:0];
  assign b_half = step_r[0] ? b_r[MUL_W-1:HALF] : b_r[HALF-1:0];

  // partial product weight
  always_comb begin
    case (pstep_r)
      2'd0:    pp_sh = {{MUL_W{1'b0}}, pp_r};
      2'd3:    pp_sh = {pp_r, {MUL_W{1'b0}}};
      default: pp_sh = {{HALF{1'b0}}, pp_r, {HALF{1'b0}}};
    endcase
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (pp_vld_r) acc_r <= acc_r + pp_sh;
      if (step_r != 3'd4) begin
        pp_r    <= a_half * b_half;
        pstep_r <= step_r[1:0];
      end
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 3'd0;
      pp_vld_r <= 1'b0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r   <= 3'd0;
        pp_vld_r <= 1'b0;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          step_r   <= step_r + 3'd1;
          pp_vld_r <= 1'b1;
        end else begin
          pp_vld_r <= 1'b0;
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/csc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_div: radix-2 restoring divider
// Unsigned 64-bit quotient, one bit per cycle; done pulses after 64 steps.
// ----------------------------------------------------------------------------
module csc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [csc_pkg::DIV_W-1:0]  num,
  input  logic [csc_pkg::DIV_W-1:0]  den,
  output logic                       done,
  output logic [csc_pkg::DIV_W-1:0]  quo
);
  import csc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  // one trial subtraction per cycle
  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/csc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_back: compressor sequencer
// Runs one item through level tracking, stage one, stage two if it engages and the
// output mix on a shared multiplier and divider, and holds the result until taken.
// ----------------------------------------------------------------------------
module csc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csc_pkg::csc_cfg_t     cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  csc_pkg::csc_item_t    q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csc_pkg::csc_result_t  out_res
);
  import csc_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_KDIV  = 18'h00002,
    ST_X1    = 18'h00004,
    ST_TMUL  = 18'h00008,
    ST_TDIV  = 18'h00010,
    ST_CMUL  = 18'h00020,
    ST_RMUL  = 18'h00040,
    ST_G1DIV = 18'h00080,
    ST_YMUL  = 18'h00100,
    ST_PMUL  = 18'h00200,
    ST_PDIV  = 18'h00400,
    ST_G2DIV = 18'h00800,
    ST_Y2MUL = 18'h01000,
    ST_W1MUL = 18'h02000,
    ST_W2MUL = 18'h04000,
    ST_DMUL  = 18'h08000,
    ST_GAMUL = 18'h10000,
    ST_OUT   = 18'h20000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic              launched_r;

  csc_item_t         item_r;
  logic [KQ_W-1:0]   k_r;
  logic [STATE_W-1:0] x1_r;
  logic [STATE_W-1:0] ctrl_r;
  logic [STATE_W-1:0] y_r;
  logic [GAIN_W-1:0] g1_r;
  logic [GAIN_W-1:0] g2_r;
  logic [63:0]       tmp_r;
  logic [63:0]       res_r;
  logic [GA_W-1:0]   gain_r;

  logic [STATE_W-1:0] tgt_r  [CHANNELS];
  logic [STATE_W-1:0] posc_r [CHANNELS];
  logic [STATE_W-1:0] negc_r [CHANNELS];
  logic [STATE_W-1:0] avg_r  [CHANNELS];

  csc_result_t       out_res_r;
  logic              out_valid_r;

  logic              mul_op;
  logic              div_op;
  logic              mul_start;
  logic              div_start;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic [DIV_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic [CH_W-1:0]    ch;
  logic [STATE_W-1:0] cur_ctl;
  logic               ctl_up;
  logic [STATE_W-1:0] ctl_diff;
  logic [STATE_W-1:0] ctl_step;
  logic [STATE_W-1:0] ctl_new;
  logic [STATE_W-1:0] y_mul;
  logic [STATE_W-1:0] avg_q;
  logic               stage2;
  logic [WET_W-1:0]   wet_w;
  logic [WET_W-1:0]   dry_w;
  logic [63:0]        mix_sum;
  logic               out_load;
  logic [SAMPLE_BITS-1:0] sat_mag;
  csc_result_t        res_c;

  csc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  csc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // helpers on the current item
  always_comb begin
    ch       = item_r.ch;
    cur_ctl  = item_r.pos ? posc_r[ch] : negc_r[ch];
    ctl_up   = (ctrl_r >= cur_ctl);
    ctl_diff = ctl_up ? (ctrl_r - cur_ctl) : (cur_ctl - ctrl_r);
    ctl_step = mul_prod[REL_SH +: STATE_W];
    ctl_new  = ctl_up ? (cur_ctl + ctl_step) : (cur_ctl - ctl_step);
    y_mul    = mul_prod[G_SH +: STATE_W];
    // divide by 1000 through the reciprocal product
    avg_q    = mul_prod[SMOOTH_SH +: STATE_W];
    // stage two when 10 * y > 11 * average
    stage2   = (({4'b0, y_r} << 3) + ({4'b0, y_r} << 1)) >
               (({4'b0, avg_q} << 3) + ({4'b0, avg_q} << 1) + {4'b0, avg_q});
    wet_w    = (cfg.wet > WET_UNITY) ? WET_UNITY : cfg.wet;
    dry_w    = WET_UNITY - wet_w;
    mix_sum  = tmp_r + mul_prod[63:0];
  end

  // operand selection for the shared units
  always_comb begin
    mul_op  = 1'b0;
    div_op  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      ST_KDIV: begin
        // compression factor, divide by 5 through the reciprocal
        mul_op = 1'b1;
        mul_a  = 64'(cfg.compress) * K_SCALE;
        mul_b  = K_RECIP;
      end
      ST_X1: begin
        mul_op = 1'b1;
        mul_a  = 64'(item_r.mag);
        mul_b  = ONE_Q32 + 64'(k_r);
      end
      ST_TMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(tgt_r[ch]);
        mul_b  = SMOOTH_M;
      end
      ST_TDIV: begin
        mul_op = 1'b1;
        mul_a  = tmp_r;
        mul_b  = SMOOTH_R;
      end
      ST_CMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(tgt_r[ch]);
        mul_b  = 64'(k_r);
      end
      ST_RMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(ctl_diff);
        mul_b  = 64'(cfg.rel_coeff);
      end
      ST_G1DIV: begin
        div_op  = 1'b1;
        div_num = Q62;
        div_den = ONE_Q32 + 64'(cur_ctl);
      end
      ST_YMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(x1_r);
        mul_b  = 64'(g1_r);
      end
      ST_PMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(avg_r[ch]);
        mul_b  = SMOOTH_M;
      end
      ST_PDIV: begin
        mul_op = 1'b1;
        mul_a  = tmp_r;
        mul_b  = SMOOTH_R;
      end
      ST_G2DIV: begin
        div_op  = 1'b1;
        div_num = Q62;
        div_den = ONE_Q32 + 64'(k_r);
      end
      ST_Y2MUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(y_r);
        mul_b  = 64'(g2_r);
      end
      ST_W1MUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(y_r);
        mul_b  = 64'(cfg.out_lvl);
      end
      ST_W2MUL: begin
        mul_op = 1'b1;
        mul_a  = tmp_r;
        mul_b  = 64'(wet_w);
      end
      ST_DMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(item_r.mag) << DRY_SH;
        mul_b  = 64'(dry_w);
      end
      ST_GAMUL: begin
        mul_op = 1'b1;
        mul_a  = 64'(g1_r);
        mul_b  = 64'(g2_r);
      end
      default: begin
        mul_op = 1'b0;
      end
    endcase
  end

  assign mul_start = mul_op && !launched_r;
  assign div_start = div_op && !launched_r;
  assign q_ready   = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_KDIV;
      ST_KDIV:  if (mul_done) state_nxt = ST_X1;
      ST_X1:    if (mul_done) state_nxt = ST_TMUL;
      ST_TMUL:  if (mul_done) state_nxt = ST_TDIV;
      ST_TDIV:  if (mul_done) state_nxt = ST_CMUL;
      ST_CMUL:  if (mul_done) state_nxt = ST_RMUL;
      ST_RMUL:  if (mul_done) state_nxt = ST_G1DIV;
      ST_G1DIV: if (div_done) state_nxt = ST_YMUL;
      ST_YMUL: begin
        // a new peak resets the average and never triggers stage two
        if (mul_done) state_nxt = (y_mul > avg_r[ch]) ? ST_W1MUL : ST_PMUL;
      end
      ST_PMUL:  if (mul_done) state_nxt = ST_PDIV;
      ST_PDIV:  if (mul_done) state_nxt = stage2 ? ST_G2DIV : ST_W1MUL;
      ST_G2DIV: if (div_done) state_nxt = ST_Y2MUL;
      ST_Y2MUL: if (mul_done) state_nxt = ST_W1MUL;
      ST_W1MUL: if (mul_done) state_nxt = ST_W2MUL;
      ST_W2MUL: if (mul_done) state_nxt = ST_DMUL;
      ST_DMUL:  if (mul_done) state_nxt = ST_GAMUL;
      ST_GAMUL: if (mul_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= q_item;
        g2_r   <= UNITY_Q30;
      end
      ST_KDIV:  if (mul_done) k_r <= mul_prod[K_SH +: KQ_W];
      ST_X1:    if (mul_done) x1_r <= mul_prod[X1_SH +: STATE_W];
      ST_TMUL:  if (mul_done) tmp_r <= mul_prod[63:0] + 64'(x1_r);
      ST_CMUL:  if (mul_done) ctrl_r <= mul_prod[CTRL_SH +: STATE_W];
      ST_G1DIV: if (div_done) g1_r <= div_quo[GAIN_W-1:0];
      ST_YMUL:  if (mul_done) y_r <= y_mul;
      ST_PMUL:  if (mul_done) tmp_r <= mul_prod[63:0] + 64'(y_r);
      ST_G2DIV: if (div_done) g2_r <= div_quo[GAIN_W-1:0];
      ST_Y2MUL: if (mul_done) y_r <= y_mul;
      ST_W1MUL: if (mul_done) tmp_r <= mul_prod[OUT_SH +: 64];
      ST_W2MUL: if (mul_done) tmp_r <= mul_prod[63:0];
      ST_DMUL:  if (mul_done) res_r <= mix_sum >> RES_SH;
      ST_GAMUL: if (mul_done) gain_r <= mul_prod[GA_SH +: GA_W];
      default: begin
        gain_r <= gain_r;
      end
    endcase
  end

  // per-channel level and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tgt_r[i]  <= '0;
        posc_r[i] <= '0;
        negc_r[i] <= '0;
        avg_r[i]  <= '0;
      end
    end else begin
      if (state_r == ST_TDIV && mul_done) tgt_r[ch] <= mul_prod[SMOOTH_SH +: STATE_W];
      if (state_r == ST_RMUL && mul_done) begin
        if (item_r.pos) posc_r[ch] <= ctl_new;
        else            negc_r[ch] <= ctl_new;
      end
      if (state_r == ST_YMUL && mul_done && (y_mul > avg_r[ch])) avg_r[ch] <= y_mul;
      if (state_r == ST_PDIV && mul_done) avg_r[ch] <= avg_q;
    end
  end

  // saturate to full scale with the input sign
  always_comb begin
    if (item_r.neg) begin
      sat_mag = (res_r > SAT_MAG) ? SAMPLE_BITS'(SAT_MAG) : res_r[SAMPLE_BITS-1:0];
    end else begin
      sat_mag = (res_r > SAT_MAG - 64'd1) ? SAMPLE_BITS'(SAT_MAG - 64'd1)
                                          : res_r[SAMPLE_BITS-1:0];
    end
    res_c.channel_out  = item_r.chbit;
    res_c.sample_out   = item_r.neg ? (SAMPLE_BITS'(0) - sat_mag) : sat_mag;
    res_c.gain_applied = gain_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) out_res_r <= res_c;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_done || div_done)      launched_r <= 1'b0;
      else if (mul_start || div_start) launched_r <= 1'b1;
      if (out_load)                  out_valid_r <= 1'b1;
      else if (out_ready)            out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ rtl/stereo_dual_stage_compressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_dual_stage_compressor: two-channel two-stage compressor
// Configuration registers, input classification front end and the
// sequenced compressor back end.
// ----------------------------------------------------------------------------
// Each sample runs through the back end on a shared radix-2 divider and a
// shared multiplier: one division on every sample (stage-one gain) and one
// more when stage two engages. The 4-step partial product multiplier forms
// 11 to 14 products per sample; the divisions by the constants 5 and 1000
// run on it as reciprocal products. A two-entry queue takes new samples while
// one is being processed, and a finished result waits in an output register
// while the next one is processed.
// Write configuration only while no sample is in flight.
module stereo_dual_stage_compressor (
  input  logic                             clk,
  input  logic                             rst_n,
  csc_in_if.sink                           in_bus,
  csc_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [csc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csc_pkg::CFG_W-1:0]        cfg_wdata
);
  import csc_pkg::*;

  csc_cfg_t    cfg_r;
  logic        q_valid;
  logic        q_ready;
  csc_item_t   q_item;
  csc_result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compress  <= COMPRESS_RST;
      cfg_r.out_lvl   <= OUTPUT_RST;
      cfg_r.wet       <= WET_RST;
      cfg_r.rel_coeff <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPRESS: cfg_r.compress  <= cfg_wdata[LVL_W-1:0];
        CFG_OUTPUT:   cfg_r.out_lvl   <= cfg_wdata[LVL_W-1:0];
        CFG_WET:      cfg_r.wet       <= cfg_wdata[WET_W-1:0];
        CFG_RELEASE:  cfg_r.rel_coeff <= cfg_wdata[REL_W-1:0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  csc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_channel (in_bus.channel),
    .in_sample  (in_bus.sample_in),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  csc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (res)
  );

  // result transfer payload
  assign out_bus.channel_out  = res.channel_out;
  assign out_bus.sample_out   = res.sample_out;
  assign out_bus.gain_applied = res.gain_applied;

endmodule

@@ rtl/csc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker: port-level checks of the stereo compressor
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module csc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [csc_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic [csc_pkg::GA_W-1:0]            out_gain
);
  import csc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_gain))
    else $error("result payload changed while stalled");

  // combined gain never exceeds unity
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain <= GA_W'(65536))
    else $error("gain above unity");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind stereo_dual_stage_compressor csc_checker u_csc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample_out),
  .out_gain   (out_bus.gain_applied)
);

@@ tb/csc_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_tb_if: stimulus types of the testbench
// The block's own input and result interfaces are used unchanged; this file
// only adds the package with the sample source classes for the stimulus.
// ----------------------------------------------------------------------------
package csc_tb_types;
  import csc_pkg::*;

  // sample source classes for stimulus
  typedef enum int {SRC_EXTREME, SRC_FULL, SRC_SCALED, SRC_QUIET} sample_src_e;
endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the stereo two-stage compressor
// Drives tagged samples with random gaps and backpressure, predicts every
// result with a bit-exact fixed-point model in a scoreboard and runs several
// register settings, extremes included, between idle phases.
// ----------------------------------------------------------------------------
module testbench;
  import csc_pkg::*;
  import csc_tb_types::*;

  localparam logic [63:0] MASK48 = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] SMASK  = (64'd1 << SAMPLE_BITS) - 64'd1;

  // compressor predictor with queue of expected results
  class comp_scoreboard;
    logic [63:0] compress, out_lvl, wet, rel_coeff;
    logic [63:0] level[CHANNELS];
    logic [63:0] pos_ctl[CHANNELS];
    logic [63:0] neg_ctl[CHANNELS];
    logic [63:0] peak_avg[CHANNELS];
    csc_result_t expected_q[$];
    int errors;

    function new();
      compress = 64'(COMPRESS_RST);
      out_lvl = 64'(OUTPUT_RST);
      wet = 64'(WET_RST);
      rel_coeff = 64'(RELEASE_RST);
      for (int i = 0; i < CHANNELS; i++) begin
        level[i] = 0; pos_ctl[i] = 0; neg_ctl[i] = 0; peak_avg[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_COMPRESS: compress = 64'(val[LVL_W-1:0]);
        CFG_OUTPUT:   out_lvl = 64'(val[LVL_W-1:0]);
        CFG_WET:      wet = 64'(val[WET_W-1:0]);
        CFG_RELEASE:  rel_coeff = 64'(val[REL_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> sh);
    endfunction

    function logic [63:0] follow(logic [63:0] cur, logic [63:0] goal);
      if (goal >= cur) return cur + mulsh(goal - cur, rel_coeff, REL_SH);
      return cur - mulsh(cur - goal, rel_coeff, REL_SH);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // accepted input transfer: advance channel state, queue the result
    function void note_input(logic chb, logic [SAMPLE_BITS-1:0] raw);
      logic [63:0] mag, k, x1, ctrl, ctl, g1, g2, y, w, wt, dry, res;
      logic neg, pos;
      int ch;
      csc_result_t r;
      ch = int'(chb) % CHANNELS;
      neg = raw[SAMPLE_BITS-1];
      mag = neg ? ((64'd1 << SAMPLE_BITS) - 64'(raw)) : 64'(raw);
      pos = !neg && mag != 0;
      k = (((compress * 64'd458752 * 64'd65536) + 64'd2) / 64'd5) >> 16;
      x1 = mulsh(mag, ONE_Q32 + k, X1_SH);
      level[ch] = (level[ch] * 64'd999 + x1) / 64'd1000;
      ctrl = mulsh(level[ch], k, CTRL_SH);
      if (pos) begin
        pos_ctl[ch] = follow(pos_ctl[ch], ctrl);
        ctl = pos_ctl[ch];
      end else begin
        neg_ctl[ch] = follow(neg_ctl[ch], ctrl);
        ctl = neg_ctl[ch];
      end
      g1 = Q62 / (ONE_Q32 + (ctl & MASK48));
      y = (x1 * g1) >> 30;
      if (y > peak_avg[ch]) peak_avg[ch] = y;
      else peak_avg[ch] = (peak_avg[ch] * 64'd999 + y) / 64'd1000;
      g2 = 64'd1 << 30;
      if (y * 64'd10 > peak_avg[ch] * 64'd11) begin
        g2 = Q62 / (ONE_Q32 + k);
        y = (y * g2) >> 30;
      end
      w = (wet > 64'd65536) ? 64'd65536 : wet;
      wt = ((y * out_lvl) >> 15) * w;
      dry = (mag << DRY_SH) * (64'd65536 - w);
      res = (wt + dry) >> RES_SH;
      if (neg) begin
        if (res > SAT_MAG) res = SAT_MAG;
        res = (64'd0 - res) & SMASK;
      end else if (res > SAT_MAG - 64'd1) begin
        res = SAT_MAG - 64'd1;
      end
      r.channel_out = chb;
      r.sample_out = res[SAMPLE_BITS-1:0];
      r.gain_applied = GA_W'((g1 * g2) >> 44);
      expected_q.push_back(r);
    endfunction

    // accepted result transfer: compare with oldest expectation
    task check(csc_result_t got);
      csc_result_t e;
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (got.channel_out !== e.channel_out)
          report($sformatf("channel_out %0d, expected %0d", got.channel_out, e.channel_out));
        if (got.sample_out !== e.sample_out)
          report($sformatf("sample_out %0d, expected %0d", got.sample_out, e.sample_out));
        if (got.gain_applied !== e.gain_applied)
          report($sformatf("gain_applied %0d, expected %0d",
                           got.gain_applied, e.gain_applied));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  bit no_idle = 1'b0;
  comp_scoreboard sb = new();

  csc_in_if in_ch();
  csc_out_if out_ch();

  stereo_dual_stage_compressor DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_ch), .out_bus(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.channel, in_ch.sample_in);
  end

  always @(posedge clk) begin
    csc_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.channel_out = out_ch.channel_out;
      got.sample_out = out_ch.sample_out;
      got.gain_applied = out_ch.gain_applied;
      sb.check(got);
    end
  end

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // result side backpressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task send_sample(logic chb, logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.channel <= chb;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // one write per call with a one-cycle enable pulse
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function logic [SAMPLE_BITS-1:0] pick_sample();
    sample_src_e src;
    logic [31:0] r;
    src = sample_src_e'($urandom_range(0, 3));
    r = $urandom();
    case (src)
      SRC_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return SAMPLE_BITS'(1);
        endcase
      end
      SRC_FULL: return r[SAMPLE_BITS-1:0];
      SRC_SCALED: return SAMPLE_BITS'($signed(r) >>> $urandom_range(8, 31));
      default: return SAMPLE_BITS'($signed(r) >>> $urandom_range(24, 31));
    endcase
  endfunction

  initial begin
    logic [SAMPLE_BITS-1:0] dir_s[12];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_COMPRESS;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.channel <= 1'b0;
    in_ch.sample_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then strong compression with extremes
    dir_s = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
              24'h400000, 24'hC00000, 24'h7FFFFF, 24'h7FFFFF, 24'h000010,
              24'h800000, 24'h000000};
    foreach (dir_s[i]) send_sample(i[0], dir_s[i]);
    drain();
    write_reg(CFG_COMPRESS, 37'd65535);
    write_reg(CFG_OUTPUT, 37'd65535);
    write_reg(CFG_WET, 37'd131071);
    write_reg(CFG_RELEASE, 37'h1F_FFFF_FFFF);
    foreach (dir_s[i]) send_sample(!i[0], dir_s[i]);
    drain();

    // random phases, extremes first
    for (int p = 0; p < 6; p++) begin
      no_idle = (p % 3 == 2);
      case (p)
        0: begin
          write_reg(CFG_COMPRESS, 37'd0);
          write_reg(CFG_OUTPUT, 37'd0);
          write_reg(CFG_WET, 37'd0);
          write_reg(CFG_RELEASE, 37'd0);
        end
        1: begin
          write_reg(CFG_COMPRESS, 37'd65535);
          write_reg(CFG_OUTPUT, 37'd65535);
          write_reg(CFG_WET, 37'd65536);
          write_reg(CFG_RELEASE, 37'h1F_FFFF_FFFF);
        end
        default: begin
          write_reg(CFG_COMPRESS, CFG_W'($urandom_range(0, 65535)));
          write_reg(CFG_OUTPUT, CFG_W'($urandom_range(0, 65535)));
          write_reg(CFG_WET, CFG_W'($urandom_range(0, 131071)));
          write_reg(CFG_RELEASE,
                    CFG_W'({$urandom_range(0, 31), $urandom()} >> $urandom_range(0, 20)));
        end
      endcase
      for (int n = 0; n < 220; n++) send_sample($urandom_range(0, 1), pick_sample());
      drain();
    end

    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/csc_pkg.sv
rtl/csc_if.sv
rtl/csc_front.sv
rtl/csc_mul.sv
rtl/csc_div.sv
rtl/csc_back.sv
rtl/stereo_dual_stage_compressor.sv
rtl/csc_checker.sv
tb/csc_tb_if.sv
tb/testbench.sv
